// ===== rtl/core/msw_pkg.sv =====
// msw_pkg: shared types and constants for the mid/side stereo widener.
// Used by every module under rtl/core; no dependencies.
package msw_pkg;

   // Default sizing
   localparam int DEF_MAX_DELAY   = 512;
   localparam int DEF_SAMPLE_BITS = 24;

   // Register file
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;
   localparam int AMT_BITS       = 17;
   localparam int LEN_BITS       = 10;
   localparam int NUM_CSRS       = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIDTH     = 3'd0,
      CSR_FOCUS     = 3'd1,
      CSR_PHASE_EN  = 3'd2,
      CSR_LEFT_LEN  = 3'd3,
      CSR_RIGHT_LEN = 3'd4
   } csr_index_type;

   localparam logic [AMT_BITS-1:0] RST_WIDTH     = 17'd32768;
   localparam logic [AMT_BITS-1:0] RST_FOCUS     = 17'd32768;
   localparam logic [LEN_BITS-1:0] RST_LEFT_LEN  = 10'd48;
   localparam logic [LEN_BITS-1:0] RST_RIGHT_LEN = 10'd72;

   // Fixed-point constants
   localparam int UNIT_ONE        = 65536;   // 1.0 in Q16
   localparam int GAIN_SIDE_FULL  = 262144;  // 2.0 in Q17
   localparam int GAIN_07_Q16     = 45875;   // 0.7 in Q16
   localparam int GAIN_BITS       = 19;      // f2 and g width
   localparam int MUL_B_BITS      = 20;      // shared multiplier B operand
   localparam int GAIN_SHIFT      = 15;
   localparam int MIX_SHIFT       = 18;
   localparam int TAP_SHIFT       = 16;

   // Sequencer to delay line control
   typedef struct packed {
      logic clear;   // restart the clearing sweep and zero the position
      logic rd_en;   // read the word at the current position
      logic wr_en;   // write the new word and advance the position
   } msw_line_ctrl_type;

endpackage

// ===== rtl/core/msw_mul.sv =====
// msw_mul: shared signed multiplier with a registered product.
// Depends on msw_pkg for the default B operand width.
module msw_mul #(
   parameter int A_BITS = 18,
   parameter int B_BITS = msw_pkg::MUL_B_BITS
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_BITS-1:0]          a,
   input  logic signed [B_BITS-1:0]          b,
   output logic signed [A_BITS+B_BITS-1:0]   prod
);

   logic signed [A_BITS+B_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= a * b;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/msw_delay_line.sv =====
// msw_delay_line: one delay store (single-port write, registered read),
// its circular position and the clearing sweep. Depends on msw_pkg.
module msw_delay_line #(
   parameter int MAX_DELAY   = msw_pkg::DEF_MAX_DELAY,
   parameter int SAMPLE_BITS = msw_pkg::DEF_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  msw_pkg::msw_line_ctrl_type         ctrl,
   input  logic [msw_pkg::LEN_BITS-1:0]       length,
   input  logic signed [SAMPLE_BITS-1:0]      wr_data,
   output logic signed [SAMPLE_BITS-1:0]      rd_data,
   output logic                               active,
   output logic                               busy
);
   import msw_pkg::*;

   localparam int AB = $clog2(MAX_DELAY);
   localparam int LW = (LEN_BITS > $clog2(MAX_DELAY + 1)) ? LEN_BITS
                                                         : $clog2(MAX_DELAY + 1);
   localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_DELAY);
   localparam logic [AB-1:0] LAST_ADDR = AB'(MAX_DELAY - 1);

   logic [SAMPLE_BITS-1:0] mem [MAX_DELAY];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [AB-1:0]          pos_ff;
   logic [AB-1:0]          pos_in;
   logic [AB-1:0]          clr_addr_ff;
   logic                   clr_busy_ff;
   logic [AB-1:0]          cur_pos;
   logic [AB-1:0]          wr_addr;
   logic [LW-1:0]          len_ext;
   logic [LW-1:0]          len_eff;
   logic [LW-1:0]          pos_next_ext;
   logic                   mem_we;
   logic [SAMPLE_BITS-1:0] mem_wdata;

   // Length saturates at the store depth
   assign len_ext      = LW'(length);
   assign len_eff      = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
   assign cur_pos      = (LW'(pos_ff) >= len_eff) ? '0 : pos_ff;
   assign pos_next_ext = LW'(cur_pos) + LW'(1);
   assign pos_in       = (pos_next_ext >= len_eff) ? '0 : cur_pos + AB'(1);

   assign mem_we    = clr_busy_ff || ctrl.wr_en;
   assign wr_addr   = clr_busy_ff ? clr_addr_ff : cur_pos;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= mem_wdata;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[cur_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         pos_ff      <= '0;
      end else if (ctrl.clear) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         pos_ff      <= '0;
      end else begin
         if (clr_busy_ff) begin
            if (clr_addr_ff == LAST_ADDR) begin
               clr_busy_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + AB'(1);
         end
         if (ctrl.wr_en) begin
            pos_ff <= pos_in;
         end
      end
   end

   assign rd_data = signed'(rd_data_ff);
   assign active  = (len_eff != '0);
   assign busy    = clr_busy_ff;

endmodule

// ===== rtl/core/mid_side_stereo_widener.sv =====
//  Channel | Ports                                   | Handshake
//  --------+-----------------------------------------+----------------------------
//  req     | req_left_in, req_right_in               | req_valid / req_ready
//  rsp     | rsp_left_out, rsp_right_out             | rsp_valid / rsp_ready
//  csr     | csr_index, csr_write_data               | csr_write_enable, no wait
//
//  One transaction steps from acceptance through GAIN, MID, SIDE, COMB and SAT,
//  then MUL_L, MUL_R and REC_R with correction on, to the load in OUT; all
//  products go through the one shared multiplier (side gain, mid term, side term,
//  then one tap per channel). Reset and every write to a defined register start
//  a clearing sweep of both delay stores, during which req_ready is low.
//  A result held in the output register while rsp_ready is low does not block
//  the next transaction; only its final load waits for the register to empty.
//
// mid_side_stereo_widener: top level, register file and sequencer.
// Depends on msw_pkg, msw_mul and msw_delay_line.
module mid_side_stereo_widener #(
   parameter int MAX_DELAY   = msw_pkg::DEF_MAX_DELAY,
   parameter int SAMPLE_BITS = msw_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]          req_right_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]          rsp_right_out,
   input  logic                                   csr_write_enable,
   input  logic [msw_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [msw_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);
   import msw_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int AW = (SB + 1 > 18) ? SB + 1 : 18;   // multiplier A width
   localparam int PW = AW + MUL_B_BITS;                // product width
   localparam int XW = PW + 2;                         // rounding headroom

   localparam logic signed [XW-1:0] ONE_W     = XW'(1);
   localparam logic signed [XW-1:0] HALF_GQ   = ONE_W <<< (GAIN_SHIFT - 1);
   localparam logic signed [XW-1:0] HALF_MIX  = ONE_W <<< (MIX_SHIFT - 1);
   localparam logic signed [XW-1:0] HALF_TAP  = ONE_W <<< (TAP_SHIFT - 1);
   localparam logic signed [XW-1:0] SAT_HI    = (ONE_W <<< (SB - 1)) - ONE_W;
   localparam logic signed [XW-1:0] SAT_LO    = -SAT_HI - ONE_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,    // w * g
      ST_MID,     // (L+R) * f2, round side gain
      ST_SIDE,    // (L-R) * gq
      ST_COMB,    // mid +/- side with rounding bias
      ST_SAT,     // shift, saturate, read both delay stores
      ST_MUL_L,   // left * 0.7
      ST_MUL_R,   // right * 0.7, left recurrence
      ST_REC_R,   // right recurrence
      ST_OUT      // load the result register
   } state_type;

   function automatic logic signed [SB-1:0] sat_word(input logic signed [XW-1:0] v);
      logic signed [SB-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SB-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SB-1:0];
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   // Registers
   state_type                  state_ff;
   logic [AMT_BITS-1:0]        width_ff;
   logic [AMT_BITS-1:0]        focus_ff;
   logic                       phase_en_ff;
   logic [LEN_BITS-1:0]        left_len_ff;
   logic [LEN_BITS-1:0]        right_len_ff;
   logic signed [SB:0]         sum_ff;
   logic signed [SB:0]         diff_ff;
   logic [MUL_B_BITS-1:0]      gq_ff;
   logic signed [PW-1:0]       mterm_ff;
   logic signed [XW-1:0]       lsum_ff;
   logic signed [XW-1:0]       rsum_ff;
   logic signed [SB-1:0]       lo_ff;
   logic signed [SB-1:0]       ro_ff;
   logic                       rsp_valid_ff;
   logic signed [SB-1:0]       rsp_left_ff;
   logic signed [SB-1:0]       rsp_right_ff;

   // Datapath
   logic [AMT_BITS-1:0]        w_eff;
   logic [AMT_BITS-1:0]        fc_eff;
   logic [GAIN_BITS-1:0]       f2;
   logic [GAIN_BITS-1:0]       g;
   logic                       mul_en;
   logic signed [AW-1:0]       mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PW-1:0]       prod;
   logic signed [XW-1:0]       gq_rnd;
   logic [MUL_B_BITS-1:0]      gq_in;
   logic signed [XW-1:0]       lsum_in;
   logic signed [XW-1:0]       rsum_in;
   logic signed [XW-1:0]       tap_rnd;
   logic signed [SB-1:0]       l_rec;
   logic signed [SB-1:0]       r_rec;
   logic signed [SB:0]         sum_in;
   logic signed [SB:0]         diff_in;
   logic                       cfg_clear;
   logic                       req_fire;

   // Delay lines
   msw_line_ctrl_type          l_ctrl;
   msw_line_ctrl_type          r_ctrl;
   logic signed [SB-1:0]       l_rd;
   logic signed [SB-1:0]       r_rd;
   logic                       l_active;
   logic                       r_active;
   logic                       l_busy;
   logic                       r_busy;

   // Gains from the registers; amounts above one saturate
   assign w_eff  = (width_ff > AMT_BITS'(UNIT_ONE)) ? AMT_BITS'(UNIT_ONE) : width_ff;
   assign fc_eff = (focus_ff > AMT_BITS'(UNIT_ONE)) ? AMT_BITS'(UNIT_ONE) : focus_ff;
   assign f2     = GAIN_BITS'(UNIT_ONE) + GAIN_BITS'(fc_eff) + GAIN_BITS'({fc_eff, 1'b0});
   assign g      = GAIN_BITS'(GAIN_SIDE_FULL) - f2;

   // Only defined register indexes clear the delay stores
   assign cfg_clear = csr_write_enable && (csr_index < CSR_INDEX_BITS'(NUM_CSRS));

   assign req_ready = (state_ff == ST_IDLE) && !l_busy && !r_busy;
   assign req_fire  = req_valid && req_ready;

   assign sum_in  = (SB + 1)'(req_left_in) + (SB + 1)'(req_right_in);
   assign diff_in = (SB + 1)'(req_left_in) - (SB + 1)'(req_right_in);

   // Shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      unique case (state_ff)
         ST_GAIN: begin
            mul_a = AW'(signed'({1'b0, w_eff}));
            mul_b = MUL_B_BITS'(signed'({1'b0, g}));
         end
         ST_MID: begin
            mul_a = AW'(sum_ff);
            mul_b = MUL_B_BITS'(signed'({1'b0, f2}));
         end
         ST_SIDE: begin
            mul_a = AW'(diff_ff);
            mul_b = signed'(gq_ff);
         end
         ST_MUL_L: begin
            mul_a = AW'(lo_ff);
            mul_b = MUL_B_BITS'(GAIN_07_Q16);
         end
         ST_MUL_R: begin
            mul_a = AW'(ro_ff);
            mul_b = MUL_B_BITS'(GAIN_07_Q16);
         end
         default: begin
            mul_en = 1'b0;
            mul_a  = '0;
            mul_b  = '0;
         end
      endcase
   end

   msw_mul #(
      .A_BITS (AW),
      .B_BITS (MUL_B_BITS)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Side gain rounds half up at 2^15; it stays below 2^19
   assign gq_rnd = XW'(prod) + HALF_GQ;
   assign gq_in  = gq_rnd[GAIN_SHIFT +: MUL_B_BITS];

   assign lsum_in = XW'(mterm_ff) + XW'(prod) + HALF_MIX;
   assign rsum_in = XW'(mterm_ff) - XW'(prod) + HALF_MIX;

   // y = round(0.7 x) - y[n-N]; the product register holds the channel in turn
   assign tap_rnd = (XW'(prod) + HALF_TAP) >>> TAP_SHIFT;
   assign l_rec   = sat_word(tap_rnd - XW'(l_rd));
   assign r_rec   = sat_word(tap_rnd - XW'(r_rd));

   // Store reads in SAT; writes land in MUL_R (left) and REC_R (right)
   assign l_ctrl.clear = cfg_clear;
   assign l_ctrl.rd_en = (state_ff == ST_SAT) && phase_en_ff;
   assign l_ctrl.wr_en = (state_ff == ST_MUL_R) && l_active;
   assign r_ctrl.clear = cfg_clear;
   assign r_ctrl.rd_en = (state_ff == ST_SAT) && phase_en_ff;
   assign r_ctrl.wr_en = (state_ff == ST_REC_R) && r_active;

   msw_delay_line #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_left_line (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (l_ctrl),
      .length  (left_len_ff),
      .wr_data (l_rec),
      .rd_data (l_rd),
      .active  (l_active),
      .busy    (l_busy)
   );

   msw_delay_line #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_right_line (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (r_ctrl),
      .length  (right_len_ff),
      .wr_data (r_rec),
      .rd_data (r_rd),
      .active  (r_active),
      .busy    (r_busy)
   );

   // Sequencer, register file and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= RST_WIDTH;
         focus_ff     <= RST_FOCUS;
         phase_en_ff  <= 1'b0;
         left_len_ff  <= RST_LEFT_LEN;
         right_len_ff <= RST_RIGHT_LEN;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_WIDTH:     width_ff     <= csr_write_data[AMT_BITS-1:0];
               CSR_FOCUS:     focus_ff     <= csr_write_data[AMT_BITS-1:0];
               CSR_PHASE_EN:  phase_en_ff  <= csr_write_data[0];
               CSR_LEFT_LEN:  left_len_ff  <= csr_write_data[LEN_BITS-1:0];
               CSR_RIGHT_LEN: right_len_ff <= csr_write_data[LEN_BITS-1:0];
               default: ;
            endcase
         end

         // the load in OUT owns the valid flag on its own edge
         if (rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  sum_ff   <= sum_in;
                  diff_ff  <= diff_in;
                  state_ff <= ST_GAIN;
               end
            end
            ST_GAIN: begin
               state_ff <= ST_MID;
            end
            ST_MID: begin
               gq_ff    <= gq_in;
               state_ff <= ST_SIDE;
            end
            ST_SIDE: begin
               mterm_ff <= prod;
               state_ff <= ST_COMB;
            end
            ST_COMB: begin
               lsum_ff  <= lsum_in;
               rsum_ff  <= rsum_in;
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               lo_ff    <= sat_word(lsum_ff >>> MIX_SHIFT);
               ro_ff    <= sat_word(rsum_ff >>> MIX_SHIFT);
               state_ff <= phase_en_ff ? ST_MUL_L : ST_OUT;
            end
            ST_MUL_L: begin
               state_ff <= ST_MUL_R;
            end
            ST_MUL_R: begin
               if (l_active) begin
                  lo_ff <= l_rec;
               end
               state_ff <= ST_REC_R;
            end
            ST_REC_R: begin
               if (r_active) begin
                  ro_ff <= r_rec;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // wait only if an untaken result still sits in the register
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_left_ff  <= lo_ff;
                  rsp_right_ff <= ro_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

// ===== rtl/core/msw_checker.sv =====
// msw_port_checker: port-level assertions for mid_side_stereo_widener,
// bound to the top level below. Depends on msw_pkg.
module msw_port_checker #(
   parameter int SAMPLE_BITS = msw_pkg::DEF_SAMPLE_BITS
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [SAMPLE_BITS-1:0]              rsp_left_out,
   input logic [SAMPLE_BITS-1:0]              rsp_right_out,
   input logic                                csr_write_enable,
   input logic [msw_pkg::CSR_INDEX_BITS-1:0]  csr_index
);
   import msw_pkg::*;

   // Leaving reset starts the store clearing sweep
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("req_ready high right after reset");

   // A write to a defined register restarts the sweep
   a_clear_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && (csr_index < CSR_INDEX_BITS'(NUM_CSRS))) |=> !req_ready)
      else $error("req_ready high right after a register write");

   // One transaction at a time: no acceptance on the following edge
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("back-to-back request acceptance");

   // Stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out)))
      else $error("stalled response dropped or changed");

endmodule

bind mid_side_stereo_widener msw_port_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_msw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_left_out     (rsp_left_out),
   .rsp_right_out    (rsp_right_out),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index)
);

// ===== tb/msw_checker.sv =====
`timescale 1ns / 1ps
// msw_checker: passive monitor for the mid/side stereo widener. Predicts every
// response from accepted requests and register writes; depends on msw_pkg.
module msw_checker #(
   parameter int MAX_DELAY   = msw_pkg::DEF_MAX_DELAY,
   parameter int SAMPLE_BITS = msw_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   input  logic signed [SAMPLE_BITS-1:0]       rsp_right_out,
   input  logic                                csr_write_enable,
   input  logic [msw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [msw_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output int                                  error_count,
   output int                                  results_pending
);
   import msw_pkg::*;

   localparam int LEFT  = 0;
   localparam int RIGHT = 1;
   localparam int REPORT_LIMIT = 10;
   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } stereo_pair_type;

   stereo_pair_type widened_pairs_due[$];

   // shadow of the register file and the two delay lines
   logic [AMT_BITS-1:0]           width_amt;
   logic [AMT_BITS-1:0]           focus_amt;
   logic                          phase_en;
   logic [LEN_BITS-1:0]           line_len [2];
   logic signed [SAMPLE_BITS-1:0] delay_line [2][MAX_DELAY];
   int                            tap_pos [2];

   // floor((v + 2^(sh-1)) / 2^sh): ties go toward +infinity
   function automatic longint round_half_up(input longint v, input int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_sample(input longint v);
      if (v > SAMPLE_HI) return SAMPLE_HI;
      if (v < SAMPLE_LO) return SAMPLE_LO;
      return v;
   endfunction

   function automatic void clear_lines();
      for (int ch = 0; ch < 2; ch++) begin
         for (int i = 0; i < MAX_DELAY; i++) delay_line[ch][i] = '0;
         tap_pos[ch] = 0;
      end
   endfunction

   // y = 0.7x - y[n-N]; saturated value is both stored and returned
   function automatic longint comb_stage(input int ch, input longint x);
      longint n;
      longint y;
      n = (line_len[ch] > MAX_DELAY) ? MAX_DELAY : line_len[ch];
      if (n == 0) return x;
      if (tap_pos[ch] >= n) tap_pos[ch] = 0;
      y = clamp_sample(round_half_up(x * GAIN_07_Q16, TAP_SHIFT)
                       - longint'(delay_line[ch][tap_pos[ch]]));
      delay_line[ch][tap_pos[ch]] = y[SAMPLE_BITS-1:0];
      tap_pos[ch] = (tap_pos[ch] + 1 >= n) ? 0 : tap_pos[ch] + 1;
      return y;
   endfunction

   function automatic stereo_pair_type widen_pair(input longint l, input longint r);
      longint w, fc, f2, g, gq, mterm, sterm, lo, ro;
      stereo_pair_type res;
      w     = (width_amt > UNIT_ONE) ? UNIT_ONE : width_amt;
      fc    = (focus_amt > UNIT_ONE) ? UNIT_ONE : focus_amt;
      f2    = UNIT_ONE + 3 * fc;
      g     = GAIN_SIDE_FULL - f2;
      gq    = round_half_up(w * g, GAIN_SHIFT);
      mterm = (l + r) * f2;
      sterm = (l - r) * gq;
      lo    = clamp_sample(round_half_up(mterm + sterm, MIX_SHIFT));
      ro    = clamp_sample(round_half_up(mterm - sterm, MIX_SHIFT));
      if (phase_en) begin
         lo = comb_stage(LEFT, lo);
         ro = comb_stage(RIGHT, ro);
      end
      res.left  = lo[SAMPLE_BITS-1:0];
      res.right = ro[SAMPLE_BITS-1:0];
      return res;
   endfunction

   // any defined register clears the lines, undefined indexes do nothing
   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_WIDTH:     width_amt = data[AMT_BITS-1:0];
         CSR_FOCUS:     focus_amt = data[AMT_BITS-1:0];
         CSR_PHASE_EN:  phase_en = data[0];
         CSR_LEFT_LEN:  line_len[LEFT] = data[LEN_BITS-1:0];
         CSR_RIGHT_LEN: line_len[RIGHT] = data[LEN_BITS-1:0];
         default:       return;
      endcase
      clear_lines();
   endfunction

   always @(posedge clock) begin : monitor
      stereo_pair_type got;
      stereo_pair_type want;
      if (reset) begin
         width_amt       = RST_WIDTH;
         focus_amt       = RST_FOCUS;
         phase_en        = 1'b0;
         line_len[LEFT]  = RST_LEFT_LEN;
         line_len[RIGHT] = RST_RIGHT_LEN;
         clear_lines();
         widened_pairs_due.delete();
         error_count = 0;
      end else begin
         if (csr_write_enable) apply_csr(csr_index, csr_write_data);
         if (req_valid && req_ready)
            widened_pairs_due.push_back(widen_pair(req_left_in, req_right_in));
         if (rsp_valid && rsp_ready) begin
            got.left  = rsp_left_out;
            got.right = rsp_right_out;
            if (widened_pairs_due.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: unexpected response left %0d right %0d",
                           $time, got.left, got.right);
               error_count++;
            end else begin
               want = widened_pairs_due.pop_front();
               if (got.left !== want.left || got.right !== want.right) begin
                  if (error_count < REPORT_LIMIT)
                     $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
                              $time, want.left, got.left, want.right, got.right);
                  error_count++;
               end
            end
         end
      end
      results_pending <= widened_pairs_due.size();
   end

endmodule

// ===== tb/tb_mid_side_stereo_widener.sv =====
`timescale 1ns / 1ps
// tb_mid_side_stereo_widener: stimulus and verdict for the stereo widener.
// Depends on msw_pkg, mid_side_stereo_widener and msw_checker.
module tb_mid_side_stereo_widener;
   import msw_pkg::*;

   localparam int SB              = DEF_SAMPLE_BITS;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int HOLD_PHASE      = 4;     // phase with the long receiver hold-off
   localparam int LONG_HOLD       = 400;   // cycles of forced rsp_ready low
   localparam int DRAIN_CYCLES    = 32;    // settle after the last response
   localparam logic [AMT_BITS-1:0] AMT_TOP = '1;
   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SB-1:0]      req_left_in = '0;
   logic signed [SB-1:0]      req_right_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SB-1:0]      rsp_left_out;
   logic signed [SB-1:0]      rsp_right_out;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   int error_count;
   int results_pending;

   // idle controls, percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_trigger  = 1'b0;

   always #6 clock = ~clock;

   mid_side_stereo_widener dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   msw_checker u_msw_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .results_pending  (results_pending)
   );

   // Receiver: random stalls, plus one long hold-off counted here so the
   // block backs up into its input while the sender keeps offering.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one transaction and return at the edge that accepts it. Valid
   // stays high afterwards so back-to-back transactions need no toggle.
   task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait for every predicted response to come back.
   // results_pending is registered, so always step at least once.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // One-cycle register write; the task returns with the write enable low again.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Full-range noise half the time, with extremes, near-extremes and small values.
   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return SB'($urandom_range(511)) - SB'(256);
         3:       return SAMPLE_MAX - SB'($urandom_range(255));
         4:       return SAMPLE_MIN + SB'($urandom_range(255));
         default: return SB'($urandom());
      endcase
   endfunction

   // Amounts: zero, exactly one, above one (saturates), or in range.
   function automatic logic [AMT_BITS-1:0] pick_amount();
      case ($urandom_range(5))
         0:       return '0;
         1:       return AMT_BITS'(UNIT_ONE);
         2:       return AMT_BITS'($urandom_range(UNIT_ONE + 1, AMT_TOP));
         default: return AMT_BITS'($urandom_range(UNIT_ONE));
      endcase
   endfunction

   // Lengths: bypass, at/over the max, mid, and mostly short so the
   // feedback taps actually come around within a phase.
   function automatic logic [LEN_BITS-1:0] pick_length();
      case ($urandom_range(7))
         0:       return '0;
         1:       return LEN_BITS'($urandom_range(DEF_MAX_DELAY, (1 << LEN_BITS) - 1));
         2:       return LEN_BITS'($urandom_range(17, DEF_MAX_DELAY - 1));
         default: return LEN_BITS'($urandom_range(1, 16));
      endcase
   endfunction

   // Every register gets a fresh value; upper data bits carry junk that the
   // narrow registers must drop. Sometimes an undefined index is thrown in.
   task automatic program_random_setting();
      logic en;
      en = ($urandom_range(3) != 0);
      write_reg(CSR_WIDTH, pick_amount());
      write_reg(CSR_FOCUS, pick_amount());
      write_reg(CSR_PHASE_EN, {16'($urandom()), en});
      write_reg(CSR_LEFT_LEN, {7'($urandom()), pick_length()});
      write_reg(CSR_RIGHT_LEN, {7'($urandom()), pick_length()});
      if ($urandom_range(2) == 0)
         write_reg(CSR_INDEX_BITS'($urandom_range(NUM_CSRS, (1 << CSR_INDEX_BITS) - 1)),
                   CSR_DATA_BITS'($urandom()));
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset setting, correction off, field extremes
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair('0, '0);
      send_pair({(SB/2){2'b01}}, {(SB/2){2'b10}});

      // zero width and focus
      wait_drained();
      write_reg(CSR_WIDTH, '0);
      write_reg(CSR_FOCUS, '0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);

      // width and focus above one clamp to one
      wait_drained();
      write_reg(CSR_WIDTH, AMT_TOP);
      write_reg(CSR_FOCUS, AMT_TOP);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(1, -1);

      // correction on, one-tap left line grows into saturation, right bypassed
      wait_drained();
      write_reg(CSR_WIDTH, AMT_BITS'(UNIT_ONE));
      write_reg(CSR_FOCUS, '0);
      write_reg(CSR_PHASE_EN, 1);
      write_reg(CSR_LEFT_LEN, 1);
      write_reg(CSR_RIGHT_LEN, 0);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);

      // undefined index must leave the line contents alone
      wait_drained();
      write_reg(CSR_INDEX_BITS'(NUM_CSRS), AMT_TOP);
      write_reg('1, AMT_TOP);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);

      // rewriting an unchanged value still clears the lines
      wait_drained();
      write_reg(CSR_LEFT_LEN, 1);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);

      // lengths at and beyond the maximum
      wait_drained();
      write_reg(CSR_LEFT_LEN, '1);
      write_reg(CSR_RIGHT_LEN, LEN_BITS'(DEF_MAX_DELAY));
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);

      // enable only looks at bit 0: writing 2 turns correction off
      wait_drained();
      write_reg(CSR_PHASE_EN, 2);
      send_pair(SAMPLE_MAX, 1);

      // --- random phases, cycling through the idle patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         program_random_setting();
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         if (p == HOLD_PHASE) hold_trigger = 1'b1;
         repeat (ITEMS_PER_PHASE) send_pair(pick_sample(), pick_sample());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("mid_side_stereo_widener regression: pass");
      else
         $display("mid_side_stereo_widener regression: fail");
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin : watchdog
      #10ms;
      $display("mid_side_stereo_widener regression: fail");
      $finish;
   end

endmodule
